// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Types and constants of the first-fit arena allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

	localparam int unsigned ARENA_BYTES_DEF = 4096;
	localparam int unsigned SPLIT_SLACK_DEF = 64;
	localparam int unsigned HDR_BYTES       = 4;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_NO_SPACE = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [11:0] request_bytes;
		logic [11:0] block_offset;
	} ffa_req_t;

	typedef struct packed {
		logic        status;
		logic [11:0] data_offset;
	} ffa_rsp_t;

endpackage

// File: sv/ffa_stream_if.sv
// ----------------------------------------------------------------------------
// ffa_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface ffa_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/ffa_ram.sv
// ----------------------------------------------------------------------------
// ffa_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// File: sv/first_fit_arena_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_arena_allocator
// First-fit block allocator over a header store, with last-freed reuse,
// splitting and a coalescing walk.
// ----------------------------------------------------------------------------
//  channel | dir | payload                              | transaction
//  req     | in  | cmd, request_bytes, block_offset     | valid && ready
//  rsp     | out | status, data_offset                  | valid && ready
//
//  One command at a time; each header visit uses the header RAM read port.
//  Free walks the headers up to the target. Allocate checks the last-freed block
//  first; on a miss it makes a first-fit walk, then if needed a coalescing walk,
//  and a grant writes the block's header, with a second write for a split.
//  req is ready only in idle. The result sits in an output register; a stalled
//  rsp holds the next result back.
//  Reset needs no clearing pass: header 0 reads as one free block until written.
`include "assert_macros.svh"

module first_fit_arena_allocator
	import ffa_pkg::*;
#(
	parameter int unsigned ARENA_BYTES = ARENA_BYTES_DEF,
	parameter int unsigned SPLIT_SLACK = SPLIT_SLACK_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ffa_stream_if.sink   req,
	ffa_stream_if.source rsp
);
	localparam int unsigned AW = $clog2(ARENA_BYTES);
	localparam int unsigned PW = AW + 1;
	localparam int unsigned DW = AW + 1;
	localparam int unsigned SW = ((AW > 13) ? AW : 13) + 1;

	localparam logic [DW-1:0] RST_HDR = {1'b1, AW'(ARENA_BYTES - HDR_BYTES)};

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_FCHK   = 8'b0000_0010,
		ST_ALF    = 8'b0000_0100,
		ST_AFF    = 8'b0000_1000,
		ST_AMW    = 8'b0001_0000,
		ST_SPLIT  = 8'b0010_0000,
		ST_SPLIT2 = 8'b0100_0000,
		ST_RESP   = 8'b1000_0000
	} state_t;

	state_t         state_q, state_d;
	logic [AW-1:0]  pos_q, pos_d;
	logic [AW-1:0]  target_q, target_d;
	logic [11:0]    req_bytes_q, req_bytes_d;
	logic [AW-1:0]  prev_q, prev_d;
	logic [AW-1:0]  prev_size_q, prev_size_d;
	logic           prev_free_q, prev_free_d;
	logic           have_prev_q, have_prev_d;
	logic [AW-1:0]  blk_q, blk_d;
	logic [AW-1:0]  blk_size_q, blk_size_d;
	logic [AW-1:0]  lf_q, lf_d;
	logic           lf_valid_q, lf_valid_d;
	logic           hdr0_ok_q;
	logic           res_status_q, res_status_d;
	logic [11:0]    res_off_q, res_off_d;
	logic           rsp_valid_q;
	logic           rsp_status_q;
	logic [11:0]    rsp_off_q;
	logic           rsp_load;

	logic           rd_en, wr_en;
	logic [AW-1:0]  rd_addr, wr_addr, rd_addr_s1;
	logic [DW-1:0]  wr_data, ram_rd_data, hdr;
	logic [AW-1:0]  hdr_size;
	logic           hdr_free;
	logic [PW-1:0]  next_pos;
	logic           next_in;
	logic           fits;
	logic [SW-1:0]  merged, keep, blk_ext, blk_off;
	logic           merged_fits, can_split;
	logic [11:0]    free_hdr;

	ffa_ram #(
		.WIDTH (DW),
		.DEPTH (1 << AW)
	) u_hdr_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (ram_rd_data)
	);

	assign hdr      = (rd_addr_s1 == '0 && !hdr0_ok_q) ? RST_HDR : ram_rd_data;
	assign hdr_size = hdr[AW-1:0];
	assign hdr_free = hdr[AW];

	assign next_pos    = PW'(pos_q) + PW'(hdr_size) + PW'(HDR_BYTES);
	assign next_in     = next_pos < PW'(ARENA_BYTES);
	assign fits        = SW'(hdr_size) >= SW'(req_bytes_q);
	assign merged      = SW'(prev_size_q) + SW'(hdr_size) + SW'(HDR_BYTES);
	assign merged_fits = merged >= SW'(req_bytes_q);
	assign keep        = SW'(req_bytes_q) + SW'(SPLIT_SLACK);
	assign can_split   = SW'(blk_size_q) >= keep + SW'(HDR_BYTES);
	assign blk_ext     = SW'(blk_q);
	assign blk_off     = blk_ext + SW'(HDR_BYTES);
	assign free_hdr    = req.data.block_offset - 12'(HDR_BYTES);

	assign req.ready = (state_q == ST_IDLE);
	assign rsp_load  = (state_q == ST_RESP) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		state_d      = state_q;
		pos_d        = pos_q;
		target_d     = target_q;
		req_bytes_d  = req_bytes_q;
		prev_d       = prev_q;
		prev_size_d  = prev_size_q;
		prev_free_d  = prev_free_q;
		have_prev_d  = have_prev_q;
		blk_d        = blk_q;
		blk_size_d   = blk_size_q;
		lf_d         = lf_q;
		lf_valid_d   = lf_valid_q;
		res_status_d = res_status_q;
		res_off_d    = res_off_q;
		rd_en        = 1'b0;
		rd_addr      = '0;
		wr_en        = 1'b0;
		wr_addr      = '0;
		wr_data      = '0;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					req_bytes_d  = req.data.request_bytes;
					res_status_d = STATUS_OK;
					res_off_d    = '0;
					pos_d        = '0;
					if (req.data.cmd == CMD_FREE) begin
						if (req.data.block_offset >= 12'(HDR_BYTES) &&
						    SW'(free_hdr) < SW'(ARENA_BYTES)) begin
							target_d = AW'(free_hdr);
							rd_en    = 1'b1;
							state_d  = ST_FCHK;
						end else begin
							state_d = ST_RESP;
						end
					end else if (lf_valid_q) begin
						rd_en   = 1'b1;
						rd_addr = lf_q;
						state_d = ST_ALF;
					end else begin
						rd_en   = 1'b1;
						state_d = ST_AFF;
					end
				end
			end
			ST_FCHK: begin
				if (pos_q == target_q) begin
					wr_en      = 1'b1;
					wr_addr    = target_q;
					wr_data    = {1'b1, hdr_size};
					lf_d       = target_q;
					lf_valid_d = 1'b1;
					state_d    = ST_RESP;
				end else if (pos_q > target_q || !next_in) begin
					state_d = ST_RESP;
				end else begin
					pos_d   = next_pos[AW-1:0];
					rd_en   = 1'b1;
					rd_addr = next_pos[AW-1:0];
				end
			end
			ST_ALF: begin
				if (hdr_free && fits) begin
					wr_en     = 1'b1;
					wr_addr   = lf_q;
					wr_data   = {1'b0, hdr_size};
					res_off_d = 12'(SW'(lf_q) + SW'(HDR_BYTES));
					state_d   = ST_RESP;
				end else begin
					pos_d   = '0;
					rd_en   = 1'b1;
					state_d = ST_AFF;
				end
			end
			ST_AFF: begin
				if (hdr_free && fits) begin
					blk_d      = pos_q;
					blk_size_d = hdr_size;
					state_d    = ST_SPLIT;
				end else if (next_in) begin
					pos_d   = next_pos[AW-1:0];
					rd_en   = 1'b1;
					rd_addr = next_pos[AW-1:0];
				end else begin
					pos_d       = '0;
					have_prev_d = 1'b0;
					rd_en       = 1'b1;
					state_d     = ST_AMW;
				end
			end
			ST_AMW: begin
				if (have_prev_q && prev_free_q && hdr_free) begin
					wr_en       = 1'b1;
					wr_addr     = prev_q;
					wr_data     = {1'b1, merged[AW-1:0]};
					prev_size_d = merged[AW-1:0];
					if (lf_valid_q && lf_q == pos_q) begin
						lf_valid_d = 1'b0;
					end
				end else begin
					prev_d      = pos_q;
					prev_size_d = hdr_size;
					prev_free_d = hdr_free;
					have_prev_d = 1'b1;
				end
				if (have_prev_q && prev_free_q && hdr_free && merged_fits) begin
					blk_d      = prev_q;
					blk_size_d = merged[AW-1:0];
					state_d    = ST_SPLIT;
				end else if (next_in) begin
					pos_d   = next_pos[AW-1:0];
					rd_en   = 1'b1;
					rd_addr = next_pos[AW-1:0];
				end else begin
					res_status_d = STATUS_NO_SPACE;
					state_d      = ST_RESP;
				end
			end
			ST_SPLIT: begin
				res_off_d = blk_off[11:0];
				wr_en     = 1'b1;
				if (can_split) begin
					wr_addr = AW'(blk_off + keep);
					wr_data = {1'b1, AW'(SW'(blk_size_q) - keep - SW'(HDR_BYTES))};
					state_d = ST_SPLIT2;
				end else begin
					wr_addr = blk_q;
					wr_data = {1'b0, blk_size_q};
					state_d = ST_RESP;
				end
			end
			ST_SPLIT2: begin
				wr_en   = 1'b1;
				wr_addr = blk_q;
				wr_data = {1'b0, keep[AW-1:0]};
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lf_valid_q  <= 1'b0;
			lf_q        <= '0;
			hdr0_ok_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			lf_valid_q <= lf_valid_d;
			lf_q       <= lf_d;
			if (wr_en && wr_addr == '0) begin
				hdr0_ok_q <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q        <= pos_d;
		target_q     <= target_d;
		req_bytes_q  <= req_bytes_d;
		prev_q       <= prev_d;
		prev_size_q  <= prev_size_d;
		prev_free_q  <= prev_free_d;
		have_prev_q  <= have_prev_d;
		blk_q        <= blk_d;
		blk_size_q   <= blk_size_d;
		res_status_q <= res_status_d;
		res_off_q    <= res_off_d;
		if (rd_en) begin
			rd_addr_s1 <= rd_addr;
		end
		if (rsp_load) begin
			rsp_status_q <= res_status_q;
			rsp_off_q    <= res_off_q;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.data.status      = rsp_status_q;
	assign rsp.data.data_offset = rsp_off_q;

	`ASSERT_IMPL(a_no_write_idle, clk, arst_n, state_q == ST_IDLE, !wr_en,
		"header write outside a command")
	`ASSERT_IMPL(a_lf_set_on_free, clk, arst_n, $rose(lf_valid_q),
		$past(state_q == ST_FCHK), "last freed marked outside a free walk")
	`ASSERT_NEXT(a_rsp_from_resp, clk, arst_n, rsp_load, rsp_valid_q,
		"loaded result not presented")
	`ASSERT_IMPL(a_fail_zero_off, clk, arst_n, rsp_valid_q && rsp_status_q,
		rsp_off_q == 12'd0, "failed allocation with nonzero offset")
endmodule
